// File: rtl/psde_pkg.sv
// ----------------------------------------------------------------------------
// psde_pkg
// Shared types, constants and CRC helper for the stored-deflate PNG encoder.
// ----------------------------------------------------------------------------
package psde_pkg;

	localparam int unsigned MAX_DIMENSION    = 16384;
	localparam int unsigned STORED_BLOCK_MAX = 65535;
	localparam int unsigned ADLER_MOD        = 65521;
	localparam logic [31:0] CRC_POLY         = 32'hEDB88320;
	localparam logic [31:0] CRC_SEED         = 32'hFFFFFFFF;

	localparam logic [5:0] HDR_LAST = 6'd42;
	localparam logic [5:0] BLK_LAST = 6'd4;
	localparam logic [5:0] TRL_LAST = 6'd19;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_BLK,
		ST_FILT,
		ST_PIX,
		ST_TRL
	} state_t;

	typedef enum logic [1:0] {
		CRC_HOLD,
		CRC_UPD,
		CRC_RST
	} crc_op_t;

	typedef struct packed {
		logic [14:0] width;
		logic [14:0] height;
		logic [30:0] raw;
		logic [14:0] blocks;
		logic [31:0] zlen;
	} geom_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/png_stored_deflate_encoder.sv
// ----------------------------------------------------------------------------
// png_stored_deflate_encoder
// RGBA8 pixel bytes in, PNG file bytes out, using stored deflate blocks.
// ----------------------------------------------------------------------------
// Input channel pixel_valid/pixel_stall/pixel_byte takes image bytes in row
// order into a four-entry queue; pixel_stall rises only when it is full.
// Output channel byte_valid/byte_stall carries out_byte, last and file_end
// from a single output register; a held byte stays until byte_stall drops.
// The first item of a file produces 43 header bytes (signature, IHDR, IDAT
// start, zlib header) before its data; a row start adds a filter byte and a
// block start adds 5 framing bytes; the image's final item adds 20 trailer
// bytes (Adler-32, IDAT CRC, IEND). One output byte leaves per cycle while
// byte_stall is low, so steady-state throughput is one item per cycle,
// bounded by the output sequencer emitting one byte per clock. Size
// registers are written on the cfg channel (always ready) and are ignored
// after a file's header is sent until the file ends; allow three cycles
// after a write before the next file starts. Reset returns both sizes to 1
// and the sequencer to the start of a file.
// ----------------------------------------------------------------------------
module png_stored_deflate_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [7:0]  pixel_byte,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        file_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data
);
	import psde_pkg::*;

	geom_t      geom;
	logic       pop, avail, busy;
	logic [7:0] head;

	psde_front u_front (
		.clk, .arst_n, .pixel_valid, .pixel_stall, .pixel_byte,
		.pop, .avail, .head
	);

	psde_geom u_geom (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.frame_busy(busy), .geom
	);

	psde_back u_back (
		.clk, .arst_n, .geom, .avail, .head, .pop, .frame_busy(busy),
		.byte_valid, .byte_stall, .out_byte, .last, .file_end
	);

endmodule

// File: rtl/psde_front.sv
// ----------------------------------------------------------------------------
// psde_front
// Input side: accepts pixel bytes into a four-entry queue for the back end.
// ----------------------------------------------------------------------------
module psde_front (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  logic [7:0] pixel_byte,
	input  logic       pop,
	output logic       avail,
	output logic [7:0] head
);
	import psde_pkg::*;

	logic [7:0] fifo_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       push;

	assign pixel_stall = (cnt_q == 3'd4);
	assign push        = pixel_valid && !pixel_stall;
	assign avail       = (cnt_q != 3'd0);
	assign head        = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= pixel_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop)  rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end

endmodule

// File: rtl/psde_geom.sv
// ----------------------------------------------------------------------------
// psde_geom
// Image size registers and the derived stream lengths.
// ----------------------------------------------------------------------------
module psde_geom (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [14:0]          cfg_data,
	input  logic                 frame_busy,
	output psde_pkg::geom_t      geom
);
	import psde_pkg::*;

	logic [14:0] width_q, height_q, clamped;
	logic [30:0] raw_q;
	logic [14:0] blocks_q;
	logic [31:0] zlen_q;
	logic [14:0] quo;
	logic [16:0] rem;
	logic [16:0] row_len;
	logic [31:0] prod;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data == 15'd0)
			clamped = 15'd1;
		else if (cfg_data > 15'(MAX_DIMENSION))
			clamped = 15'(MAX_DIMENSION);
		else
			clamped = cfg_data;
	end

	assign row_len = {width_q, 2'b00} + 17'd1;
	assign prod    = height_q * row_len;
	assign quo     = raw_q[30:16];
	assign rem     = {1'b0, raw_q[15:0]} + {2'b00, quo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 15'd1;
			height_q <= 15'd1;
		end else if (cfg_valid && cfg_ready && !frame_busy) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= clamped;
				CFG_HEIGHT: height_q <= clamped;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		raw_q <= prod[30:0];
		if (rem == 17'd0)
			blocks_q <= quo;
		else if (rem > 17'(STORED_BLOCK_MAX))
			blocks_q <= quo + 15'd2;
		else
			blocks_q <= quo + 15'd1;
		zlen_q <= 32'd6 + ({17'd0, blocks_q} * 32'd5) + {1'b0, raw_q};
	end

	assign geom = '{width: width_q, height: height_q, raw: raw_q,
		blocks: blocks_q, zlen: zlen_q};

endmodule

// File: rtl/psde_back.sv
// ----------------------------------------------------------------------------
// psde_back
// Byte sequencer: headers, block framing, checksums and the output register.
// ----------------------------------------------------------------------------
module psde_back (
	input  logic            clk,
	input  logic            arst_n,
	input  psde_pkg::geom_t geom,
	input  logic            avail,
	input  logic [7:0]      head,
	output logic            pop,
	output logic            frame_busy,
	output logic            byte_valid,
	input  logic            byte_stall,
	output logic [7:0]      out_byte,
	output logic            last,
	output logic            file_end
);
	import psde_pkg::*;

	state_t      st_q, st_eff, st_d;
	logic [5:0]  idx_q, idx_d;
	logic        started_q;
	logic [30:0] pos_q;
	logic [16:0] col_q;
	logic [15:0] blk_rem_q;
	logic [14:0] blocks_left_q;
	logic [15:0] adl_lo_q, adl_hi_q;
	logic [31:0] crc_q;
	logic        ov_q, last_q, fend_q;
	logic [7:0]  ob_q;

	logic        adv, pix_done, blk_end, trl_end;
	logic [7:0]  b;
	crc_op_t     cop;
	logic [31:0] crc_x, zl, w32, h32, adl32;
	logic [30:0] left;
	logic [15:0] blen, nlen;
	logic [16:0] row_len, lo_sum, hi_sum;
	logic [15:0] lo_n, hi_n;
	logic [7:0]  raw_b;

	assign row_len  = {geom.width, 2'b00} + 17'd1;
	assign left     = geom.raw - pos_q;
	assign blen     = (left < 31'(STORED_BLOCK_MAX)) ? left[15:0] : 16'hFFFF;
	assign nlen     = ~blen;
	assign crc_x    = crc_q ^ CRC_SEED;
	assign zl       = geom.zlen;
	assign w32      = {17'd0, geom.width};
	assign h32      = {17'd0, geom.height};
	assign adl32    = {adl_hi_q, adl_lo_q};
	assign pix_done = (pos_q + 31'd1 == geom.raw);

	// next state
	always_comb begin
		st_eff = st_q;
		if (st_q == ST_IDLE) begin
			if (!avail)
				st_eff = ST_IDLE;
			else if (!started_q)
				st_eff = ST_HDR;
			else if (blk_rem_q == 16'd0)
				st_eff = ST_BLK;
			else if (col_q == 17'd0)
				st_eff = ST_FILT;
			else
				st_eff = ST_PIX;
		end
		adv   = (st_eff != ST_IDLE) && (!ov_q || !byte_stall);
		st_d  = st_q;
		idx_d = idx_q;
		if (adv) begin
			idx_d = idx_q + 6'd1;
			st_d  = st_eff;
			case (st_eff)
				ST_HDR: if (idx_q == HDR_LAST) begin
					st_d  = ST_IDLE;
					idx_d = 6'd0;
				end
				ST_BLK: if (idx_q == BLK_LAST) begin
					st_d  = ST_IDLE;
					idx_d = 6'd0;
				end
				ST_FILT: begin
					st_d  = ST_IDLE;
					idx_d = 6'd0;
				end
				ST_PIX: begin
					st_d  = pix_done ? ST_TRL : ST_IDLE;
					idx_d = 6'd0;
				end
				ST_TRL: if (idx_q == TRL_LAST) begin
					st_d  = ST_IDLE;
					idx_d = 6'd0;
				end
				default: begin
					st_d  = ST_IDLE;
					idx_d = 6'd0;
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		b   = 8'h00;
		cop = CRC_HOLD;
		case (st_eff)
			ST_HDR: begin
				case (idx_q)
					6'd0:  begin b = 8'd137; cop = CRC_RST; end
					6'd1:  b = 8'd80;
					6'd2:  b = 8'd78;
					6'd3:  b = 8'd71;
					6'd4:  b = 8'd13;
					6'd5:  b = 8'd10;
					6'd6:  b = 8'd26;
					6'd7:  b = 8'd10;
					6'd11: b = 8'd13;
					6'd12: b = 8'h49;
					6'd13: b = 8'h48;
					6'd14: b = 8'h44;
					6'd15: b = 8'h52;
					6'd16: b = w32[31:24];
					6'd17: b = w32[23:16];
					6'd18: b = w32[15:8];
					6'd19: b = w32[7:0];
					6'd20: b = h32[31:24];
					6'd21: b = h32[23:16];
					6'd22: b = h32[15:8];
					6'd23: b = h32[7:0];
					6'd24: b = 8'd8;
					6'd25: b = 8'd6;
					6'd29: b = crc_x[31:24];
					6'd30: b = crc_x[23:16];
					6'd31: b = crc_x[15:8];
					6'd32: b = crc_x[7:0];
					6'd33: b = zl[31:24];
					6'd34: b = zl[23:16];
					6'd35: b = zl[15:8];
					6'd36: b = zl[7:0];
					6'd37: b = 8'h49;
					6'd38: b = 8'h44;
					6'd39: b = 8'h41;
					6'd40: b = 8'h54;
					6'd41: b = 8'h78;
					6'd42: b = 8'h01;
					default: b = 8'h00;
				endcase
				if (idx_q inside {[6'd12:6'd28], [6'd37:6'd42]})
					cop = CRC_UPD;
				else if (idx_q == 6'd32)
					cop = CRC_RST;
			end
			ST_BLK: begin
				cop = CRC_UPD;
				case (idx_q)
					6'd0:    b = {7'd0, (blocks_left_q <= 15'd1)};
					6'd1:    b = blen[7:0];
					6'd2:    b = blen[15:8];
					6'd3:    b = nlen[7:0];
					default: b = nlen[15:8];
				endcase
			end
			ST_FILT: begin
				cop = CRC_UPD;
				b   = 8'h00;
			end
			ST_PIX: begin
				cop = CRC_UPD;
				b   = head;
			end
			ST_TRL: begin
				case (idx_q)
					6'd0:  b = adl32[31:24];
					6'd1:  b = adl32[23:16];
					6'd2:  b = adl32[15:8];
					6'd3:  b = adl32[7:0];
					6'd4:  b = crc_x[31:24];
					6'd5:  b = crc_x[23:16];
					6'd6:  b = crc_x[15:8];
					6'd7:  b = crc_x[7:0];
					6'd12: b = 8'h49;
					6'd13: b = 8'h45;
					6'd14: b = 8'h4E;
					6'd15: b = 8'h44;
					6'd16: b = crc_x[31:24];
					6'd17: b = crc_x[23:16];
					6'd18: b = crc_x[15:8];
					6'd19: b = crc_x[7:0];
					default: b = 8'h00;
				endcase
				if (idx_q inside {[6'd0:6'd3], [6'd12:6'd15]})
					cop = CRC_UPD;
				else if (idx_q == 6'd7)
					cop = CRC_RST;
			end
			default: ;
		endcase
	end

	assign blk_end = adv && (st_eff == ST_BLK) && (idx_q == BLK_LAST);
	assign trl_end = adv && (st_eff == ST_TRL) && (idx_q == TRL_LAST);
	assign pop     = adv && (st_eff == ST_PIX);
	assign raw_b   = (st_eff == ST_PIX) ? head : 8'h00;

	assign lo_sum = {1'b0, adl_lo_q} + {9'd0, raw_b};
	assign lo_n   = (lo_sum >= 17'(ADLER_MOD)) ? 16'(lo_sum - 17'(ADLER_MOD)) : lo_sum[15:0];
	assign hi_sum = {1'b0, adl_hi_q} + {1'b0, lo_n};
	assign hi_n   = (hi_sum >= 17'(ADLER_MOD)) ? 16'(hi_sum - 17'(ADLER_MOD)) : hi_sum[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			idx_q         <= 6'd0;
			started_q     <= 1'b0;
			pos_q         <= 31'd0;
			col_q         <= 17'd0;
			blk_rem_q     <= 16'd0;
			blocks_left_q <= 15'd0;
			adl_lo_q      <= 16'd1;
			adl_hi_q      <= 16'd0;
			crc_q         <= CRC_SEED;
			ov_q          <= 1'b0;
		end else begin
			st_q  <= st_d;
			idx_q <= idx_d;
			if (!ov_q || !byte_stall)
				ov_q <= adv;
			if (adv) begin
				case (cop)
					CRC_UPD: crc_q <= crc32_byte(crc_q, b);
					CRC_RST: crc_q <= CRC_SEED;
					default: ;
				endcase
			end
			if (adv && st_eff == ST_HDR && idx_q == HDR_LAST) begin
				started_q     <= 1'b1;
				pos_q         <= 31'd0;
				col_q         <= 17'd0;
				blk_rem_q     <= 16'd0;
				blocks_left_q <= geom.blocks;
				adl_lo_q      <= 16'd1;
				adl_hi_q      <= 16'd0;
			end
			if (blk_end) begin
				blk_rem_q <= blen;
				if (blocks_left_q != 15'd0)
					blocks_left_q <= blocks_left_q - 15'd1;
			end
			if (adv && (st_eff == ST_FILT || st_eff == ST_PIX)) begin
				pos_q     <= pos_q + 31'd1;
				blk_rem_q <= blk_rem_q - 16'd1;
				adl_lo_q  <= lo_n;
				adl_hi_q  <= hi_n;
				if (st_eff == ST_FILT)
					col_q <= 17'd1;
				else if (col_q + 17'd1 >= row_len)
					col_q <= 17'd0;
				else
					col_q <= col_q + 17'd1;
			end
			if (trl_end)
				started_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ob_q   <= b;
			last_q <= (st_eff == ST_PIX && !pix_done) || (st_eff == ST_TRL && idx_q == TRL_LAST);
			fend_q <= (st_eff == ST_TRL && idx_q == TRL_LAST);
		end
	end

	assign frame_busy = started_q;
	assign byte_valid = ov_q;
	assign out_byte   = ob_q;
	assign last       = last_q;
	assign file_end   = fend_q;

	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && file_end |-> last)
		else $error("file_end without last");
	a_trl_clears: assert property (@(posedge clk) disable iff (!arst_n)
		trl_end |=> !started_q)
		else $error("frame still open after trailer");
	a_pix_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (blk_rem_q != 16'd0) && started_q && (col_q != 17'd0))
		else $error("pixel emitted outside an open block or row");

endmodule

// File: dv/png_stored_deflate_encoder_tb.sv
// ----------------------------------------------------------------------------
// png_stored_deflate_encoder_tb
// Streams small RGBA8 images of many sizes through the encoder. A local PNG
// byte predictor queues the expected bytes, and every output byte is
// compared with them. Both channels idle and stall at random, with one calm
// stretch.
// ----------------------------------------------------------------------------
module png_stored_deflate_encoder_tb;
	import psde_pkg::*;

	localparam int unsigned RUN_LIMIT = 2_000_000;

	typedef struct packed {
		logic [7:0] data;
		logic       lst;
		logic       fend;
	} png_byte_t;

	typedef struct packed {
		logic        is_cfg;
		logic        idx;
		logic [14:0] val;
		logic [7:0]  px;
		logic        chk;
		logic [7:0]  first;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pixel_valid = 1'b0;
	logic        pixel_stall;
	logic [7:0]  pixel_byte = '0;
	logic        byte_valid;
	logic        byte_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last;
	logic        file_end;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_WIDTH;
	logic [14:0] cfg_data = '0;

	png_byte_t   png_expected[$];
	png_byte_t   step_bytes[$];
	logic [31:0] crc_tab[256];
	int          idle_pct = 18;
	int          mismatches = 0;
	int unsigned cycles = 0;
	int          pixels_sent = 0;

	// predictor state
	int unsigned img_w, img_h, raw_pos, row_col, blk_rem, blks_left;
	int unsigned ad_lo, ad_hi;
	logic [31:0] crc;
	bit          in_file;

	png_stored_deflate_encoder DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int unsigned raw_len();
		return img_h * (img_w * 4 + 1);
	endfunction

	function automatic void put(int unsigned v, bit into_crc);
		logic [7:0] b;
		b = v[7:0];
		if (into_crc)
			crc = crc_tab[(crc[7:0] ^ b)] ^ (crc >> 8);
		step_bytes.push_back('{b, 1'b0, 1'b0});
	endfunction

	function automatic void put32(logic [31:0] v, bit into_crc);
		for (int i = 3; i >= 0; i--)
			put(v[i*8 +: 8], into_crc);
	endfunction

	function automatic void put_tag(string s);
		for (int i = 0; i < 4; i++)
			put(s[i], 1'b1);
	endfunction

	function automatic void put_raw(int unsigned v);
		int unsigned left, len;
		if (blk_rem == 0) begin
			left = raw_len() - raw_pos;
			len = (left < STORED_BLOCK_MAX) ? left : STORED_BLOCK_MAX;
			put((blks_left <= 1) ? 1 : 0, 1'b1);
			put(len, 1'b1);
			put(len >> 8, 1'b1);
			put(~len, 1'b1);
			put(~len >> 8, 1'b1);
			blk_rem = len;
			if (blks_left > 0)
				blks_left--;
		end
		put(v, 1'b1);
		ad_lo += v;
		if (ad_lo >= ADLER_MOD)
			ad_lo -= ADLER_MOD;
		ad_hi += ad_lo;
		if (ad_hi >= ADLER_MOD)
			ad_hi -= ADLER_MOD;
		raw_pos++;
		blk_rem--;
	endfunction

	// returns first byte produced by this item
	function automatic logic [7:0] png_predict(logic [7:0] px);
		byte unsigned sig[8] = '{137, 80, 78, 71, 13, 10, 26, 10};
		int unsigned raw, blocks;
		step_bytes.delete();
		if (!in_file) begin
			raw = raw_len();
			blocks = (raw + STORED_BLOCK_MAX - 1) / STORED_BLOCK_MAX;
			raw_pos = 0;
			row_col = 0;
			blk_rem = 0;
			blks_left = blocks;
			ad_lo = 1;
			ad_hi = 0;
			foreach (sig[i])
				put(sig[i], 1'b0);
			crc = CRC_SEED;
			put32(13, 1'b0);
			put_tag("IHDR");
			put32(img_w, 1'b1);
			put32(img_h, 1'b1);
			put(8, 1'b1);
			put(6, 1'b1);
			put(0, 1'b1);
			put(0, 1'b1);
			put(0, 1'b1);
			put32(crc ^ CRC_SEED, 1'b0);
			crc = CRC_SEED;
			put32(2 + 5 * blocks + raw + 4, 1'b0);
			put_tag("IDAT");
			put(8'h78, 1'b1);
			put(8'h01, 1'b1);
			in_file = 1'b1;
		end
		if (row_col == 0) begin
			put_raw(0);
			row_col = 1;
		end
		put_raw(px);
		row_col++;
		if (row_col >= img_w * 4 + 1)
			row_col = 0;
		if (raw_pos >= raw_len()) begin
			put32({ad_hi[15:0], ad_lo[15:0]}, 1'b1);
			put32(crc ^ CRC_SEED, 1'b0);
			crc = CRC_SEED;
			put32(0, 1'b0);
			put_tag("IEND");
			put32(crc ^ CRC_SEED, 1'b0);
			in_file = 1'b0;
			step_bytes[$].fend = 1'b1;
		end
		step_bytes[$].lst = 1'b1;
		foreach (step_bytes[i])
			png_expected.push_back(step_bytes[i]);
		return step_bytes[0].data;
	endfunction

	task automatic send_pixel(logic [7:0] b, bit chk = 1'b0, logic [7:0] first = '0);
		logic [7:0] got;
		while ($urandom_range(0, 99) < idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_byte <= b;
		do @(posedge clk); while (pixel_stall);
		got = png_predict(b);
		pixels_sent++;
		if (chk && got !== first) begin
			mismatches++;
			if (mismatches <= 10)
				$display("first byte of item: expected %0d, predicted %0d", first, got);
		end
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (png_expected.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_size(logic idx, logic [14:0] v);
		int unsigned s;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		s = (v == 0) ? 1 : ((v > MAX_DIMENSION) ? MAX_DIMENSION : v);
		if (!in_file) begin
			if (idx == CFG_WIDTH)
				img_w = s;
			else
				img_h = s;
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic send_image();
		for (int i = 0; i < img_w * img_h * 4; i++)
			send_pixel(8'($urandom_range(0, 255)));
	endtask

	always @(posedge clk) begin
		png_byte_t e;
		if (byte_valid && !byte_stall) begin
			if (png_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected byte %02h", out_byte);
			end else begin
				e = png_expected.pop_front();
				if (out_byte !== e.data || last !== e.lst || file_end !== e.fend) begin
					mismatches++;
					if (mismatches <= 10)
						$display("byte mismatch: expected %02h/%b/%b, got %02h/%b/%b",
							e.data, e.lst, e.fend, out_byte, last, file_end);
				end
			end
		end
		byte_stall <= ($urandom_range(0, 99) < idle_pct);
	end

	row_t dir_rows[] = '{
		'{1'b0, CFG_WIDTH, 15'd0, 8'h00, 1'b1, 8'd137},
		'{1'b0, CFG_WIDTH, 15'd0, 8'hFF, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'h80, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'h7F, 1'b0, 8'd0},
		'{1'b1, CFG_WIDTH, 15'd0, 8'h00, 1'b0, 8'd0},
		'{1'b1, CFG_HEIGHT, 15'd2, 8'h00, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'hAA, 1'b1, 8'd137},
		'{1'b0, CFG_WIDTH, 15'd0, 8'h55, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'h01, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'hFE, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'h0F, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'hF0, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'h33, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'hCC, 1'b0, 8'd0},
		'{1'b1, CFG_HEIGHT, 15'd32767, 8'h00, 1'b0, 8'd0},
		'{1'b1, CFG_HEIGHT, 15'd0, 8'h00, 1'b0, 8'd0},
		'{1'b1, CFG_WIDTH, 15'd2, 8'h00, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'hFF, 1'b1, 8'd137},
		'{1'b0, CFG_WIDTH, 15'd0, 8'hFF, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'hFF, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'hFF, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'h00, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'h00, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'h00, 1'b0, 8'd0},
		'{1'b0, CFG_WIDTH, 15'd0, 8'h00, 1'b0, 8'd0}
	};

	initial begin
		int files;
		for (int n = 0; n < 256; n++) begin
			crc_tab[n] = n;
			for (int k = 0; k < 8; k++)
				crc_tab[n] = crc_tab[n][0] ? ((crc_tab[n] >> 1) ^ CRC_POLY) : (crc_tab[n] >> 1);
		end
		img_w = 1;
		img_h = 1;
		in_file = 1'b0;
		crc = CRC_SEED;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				drain();
				write_size(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_pixel(dir_rows[i].px, dir_rows[i].chk, dir_rows[i].first);
			end
		end

		files = 0;
		while (pixels_sent < 355) begin
			drain();
			idle_pct = (files >= 6 && files < 10) ? 0 : 18;
			case ($urandom_range(0, 5))
				0: write_size(CFG_WIDTH, 15'd0);
				1: write_size(CFG_WIDTH, 15'($urandom_range(16385, 32767)));
				default: ;
			endcase
			write_size(CFG_WIDTH, 15'($urandom_range(1, 6)));
			write_size(CFG_HEIGHT, 15'($urandom_range(1, 4)));
			send_image();
			files++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && png_expected.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
